// File: rtl/nmea_sentence_capture_assert.svh
// Assertion macros shared by the capture block.
// Depends on nothing; take in with `include inside a module body.
`ifndef NMEA_SENTENCE_CAPTURE_ASSERT_SVH
`define NMEA_SENTENCE_CAPTURE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/nmea_cap_pkg.sv
// Package for the NMEA sentence capture block: operation codes, widths,
// character constants and prefix match helpers. Depends on nothing.
package nmea_cap_pkg;

   localparam int BUF_DEPTH_DEF = 512;
   localparam int DATA_W        = 8;
   localparam int ADDR_W        = 9;
   localparam int LEN_W         = 10;
   localparam int PREFIX_LEN    = 5;
   localparam int MATCH_MIN     = 6;

   typedef enum logic [1:0] {
      OP_RECV    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_READ    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef logic [PREFIX_LEN-1:0][DATA_W-1:0] prefix_type;

   localparam logic [DATA_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [DATA_W-1:0] CH_G      = 8'h47;
   localparam logic [DATA_W-1:0] CH_P      = 8'h50;
   localparam logic [DATA_W-1:0] CH_N      = 8'h4E;
   localparam logic [DATA_W-1:0] CH_R      = 8'h52;
   localparam logic [DATA_W-1:0] CH_M      = 8'h4D;
   localparam logic [DATA_W-1:0] CH_C      = 8'h43;
   localparam logic [DATA_W-1:0] CH_A      = 8'h41;

   // GP or GN talker
   function automatic logic talker_ok(prefix_type p);
      return (p[0] == CH_G) && ((p[1] == CH_P) || (p[1] == CH_N));
   endfunction

   function automatic logic is_rmc(prefix_type p);
      return talker_ok(p) && (p[2] == CH_R) && (p[3] == CH_M) && (p[4] == CH_C);
   endfunction

   function automatic logic is_gga(prefix_type p);
      return talker_ok(p) && (p[2] == CH_G) && (p[3] == CH_G) && (p[4] == CH_A);
   endfunction

endpackage

// File: rtl/nmea_cap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Defaults come from nmea_cap_pkg.
module nmea_cap_ram #(
   parameter int WIDTH = nmea_cap_pkg::DATA_W,
   parameter int DEPTH = nmea_cap_pkg::BUF_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/nmea_sentence_capture.sv
// NMEA sentence capture. Receiver bytes go into a BUF_DEPTH-byte capture RAM;
// a '$' restarts capture, or closes the frame once an RMC sentence has been
// recognized, and the first five held bytes are matched against GP/GN RMC
// and GGA to raise the type flags. Each request transaction (receive, release,
// read, clear flags) yields exactly one response transaction showing the
// state after the operation. One transaction is accepted per cycle while
// req_stall is low; each response passes the registered read port of the
// capture RAM and stage 1, then the response register. Reads at or beyond
// the stored length return zero. Depends on nmea_cap_pkg, nmea_cap_ram and
// nmea_sentence_capture_assert.svh.
module nmea_sentence_capture #(
   parameter int BUF_DEPTH = nmea_cap_pkg::BUF_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [nmea_cap_pkg::DATA_W-1:0]   req_data_byte,
   input  logic [nmea_cap_pkg::ADDR_W-1:0]   req_read_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nmea_cap_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                              rsp_frame_ready,
   output logic                              rsp_rmc_seen,
   output logic                              rsp_gga_seen,
   output logic [nmea_cap_pkg::LEN_W-1:0]    rsp_stored_length
);

   localparam int FILL_W = $clog2(BUF_DEPTH + 1);
   localparam int RAM_AW = $clog2(BUF_DEPTH);
   localparam int CMP_W  = (FILL_W > nmea_cap_pkg::ADDR_W) ? FILL_W : nmea_cap_pkg::ADDR_W;
   localparam int DW     = nmea_cap_pkg::DATA_W;
   localparam int LW     = nmea_cap_pkg::LEN_W;

   // Capture state
   logic [FILL_W-1:0]        fill_ff,  fill_in;
   logic                     ready_ff, ready_in;
   logic                     rmc_ff,   rmc_in;
   logic                     gga_ff,   gga_in;
   nmea_cap_pkg::prefix_type prefix_ff, prefix_in;

   // Stage 1: RAM read in flight
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_rd_sel_ff, s1_rd_sel_in;
   logic          s1_ready_ff, s1_rmc_ff, s1_gga_ff;
   logic [LW-1:0] s1_len_ff;

   // Stage 2: response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_ready_ff, rsp_rmc_ff, rsp_gga_ff;
   logic [LW-1:0] rsp_len_ff;

   nmea_cap_pkg::op_type op;
   logic                 accept;
   logic                 s2_free;
   logic                 s1_move;
   logic                 has_room;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [DW-1:0]        ram_rd_data;

   assign op = nmea_cap_pkg::op_type'(req_operation);

   // Handshake: stage 1 drains into the response register whenever that
   // register is empty or being taken; hold the request side only when
   // stage 1 is full and cannot move.
   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign accept    = req_valid && !req_stall;

   assign has_room  = fill_ff < FILL_W'(BUF_DEPTH);
   assign ram_wr_en = accept && (op == nmea_cap_pkg::OP_RECV) && has_room;
   assign ram_rd_en = accept && (op == nmea_cap_pkg::OP_READ);

   // Store every received byte while there is room; a read needs no
   // forwarding since a write always commits at the edge before any later read.
   nmea_cap_ram #(
      .WIDTH (DW),
      .DEPTH (BUF_DEPTH)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (RAM_AW'(fill_ff)),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (RAM_AW'(req_read_address)),
      .rd_data (ram_rd_data)
   );

   // Next capture state for the accepted transaction.
   always_comb begin
      fill_in   = fill_ff;
      ready_in  = ready_ff;
      rmc_in    = rmc_ff;
      gga_in    = gga_ff;
      prefix_in = prefix_ff;
      if (accept) begin
         case (op)
            nmea_cap_pkg::OP_RECV: begin
               if (has_room) begin
                  if (fill_ff < FILL_W'(nmea_cap_pkg::PREFIX_LEN)) begin
                     prefix_in[fill_ff[2:0]] = req_data_byte;
                  end
                  fill_in = fill_ff + FILL_W'(1);
               end
               // Once the frame is ready, keep storing but ignore framing.
               if (!ready_ff) begin
                  if (req_data_byte == nmea_cap_pkg::CH_DOLLAR) begin
                     if (rmc_ff) begin
                        ready_in = 1'b1;
                     end else begin
                        fill_in = '0;
                     end
                  end else if ((!rmc_ff || !gga_ff) &&
                               (fill_in > FILL_W'(nmea_cap_pkg::MATCH_MIN))) begin
                     // Prefix is settled here: more than six bytes are held.
                     if (nmea_cap_pkg::is_rmc(prefix_ff)) begin
                        rmc_in = 1'b1;
                     end
                     if (nmea_cap_pkg::is_gga(prefix_ff)) begin
                        gga_in = 1'b1;
                     end
                  end
               end
            end
            nmea_cap_pkg::OP_RELEASE: begin
               fill_in  = '0;
               ready_in = 1'b0;
            end
            nmea_cap_pkg::OP_READ: begin
               fill_in = fill_ff;
            end
            nmea_cap_pkg::OP_CLEAR: begin
               rmc_in = 1'b0;
               gga_in = 1'b0;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   // Positions below the fill count are always within the buffer.
   assign s1_rd_sel_in = ram_rd_en && (CMP_W'(req_read_address) < CMP_W'(fill_ff));
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = s1_rd_sel_ff ? ram_rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         ready_ff  <= 1'b0;
         rmc_ff    <= 1'b0;
         gga_ff    <= 1'b0;
         prefix_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         ready_ff  <= ready_in;
         rmc_ff    <= rmc_in;
         gga_ff    <= gga_in;
         prefix_ff <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1 payload: the state after the operation, captured on accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_sel_ff <= s1_rd_sel_in;
         s1_ready_ff  <= ready_in;
         s1_rmc_ff    <= rmc_in;
         s1_gga_ff    <= gga_in;
         s1_len_ff    <= LW'(fill_in);
      end
   end

   // Response payload: advance only when stage 1 moves, else hold.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_ready_ff <= s1_ready_ff;
         rsp_rmc_ff   <= s1_rmc_ff;
         rsp_gga_ff   <= s1_gga_ff;
         rsp_len_ff   <= s1_len_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_frame_ready   = rsp_ready_ff;
   assign rsp_rmc_seen      = rsp_rmc_ff;
   assign rsp_gga_seen      = rsp_gga_ff;
   assign rsp_stored_length = rsp_len_ff;

`include "nmea_sentence_capture_assert.svh"

   `NSC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(BUF_DEPTH),
      "fill index beyond buffer depth")

   `NSC_ASSERT_NOW(a_ready_needs_rmc, clock, reset, $rose(ready_ff), rmc_ff,
      "frame ready raised without an RMC sentence")

   `NSC_ASSERT_NEXT(a_release_empties, clock, reset,
      accept && (op == nmea_cap_pkg::OP_RELEASE), (fill_ff == '0) && !ready_ff,
      "release did not empty the buffer")

endmodule
